// ===== hw/rtl/rgbhsv_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Shared widths, constants, pipeline types and the divider step function.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

   // Field widths of the pixel and of the result.
   localparam int CHAN_W  = 8;
   localparam int HUE_W   = 15;
   localparam int SAT_W   = 16;
   localparam int REQ_W   = 3 * CHAN_W;
   localparam int RSP_W   = 40;

   // Hue is in degrees times 64: one sector is 60 degrees, a full turn 360.
   localparam logic [14:0] HUE_SCALE = 15'd3840;
   localparam logic [14:0] HUE_FULL  = 15'd23040;

   // Divider geometry: a 24-bit dividend over an 8-bit divisor, 16 quotient bits.
   localparam int QUO_W          = 16;
   localparam int DIVIDEND_W     = CHAN_W + QUO_W;
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;

   // Sector of the hue circle, picked by the largest channel.
   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

   // One division in flight: partial remainder, dividend bits still to be
   // consumed (shifting out at the top) with quotient bits shifting in below.
   typedef struct packed {
      logic [CHAN_W-1:0] rem;
      logic [QUO_W-1:0]  bits;
      logic [CHAN_W-1:0] dvs;
   } lane_type;

   // Payload of one item inside the divider pipeline.
   typedef struct packed {
      logic [CHAN_W-1:0] value;
      lane_type          sat;
      lane_type          hue;
   } div_stage_type;

   // One restoring division step. The remainder always stays below the divisor.
   function automatic lane_type div_step(lane_type l);
      logic [CHAN_W:0] trial;
      logic [CHAN_W:0] less;
      lane_type        o;
      trial = {l.rem, l.bits[QUO_W-1]};
      less  = trial - {1'b0, l.dvs};
      o     = l;
      if (trial >= {1'b0, l.dvs}) begin
         o.rem  = less[CHAN_W-1:0];
         o.bits = {l.bits[QUO_W-2:0], 1'b1};
      end else begin
         o.rem  = trial[CHAN_W-1:0];
         o.bits = {l.bits[QUO_W-2:0], 1'b0};
      end
      return o;
   endfunction

endpackage

// ===== hw/rtl/rgbhsv_front.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV front end
// Two register stages: channel max, min and sector, then the two dividends.
// ----------------------------------------------------------------------------
module rgbhsv_front
   import rgbhsv_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [CHAN_W-1:0]   red,
   input  logic [CHAN_W-1:0]   green,
   input  logic [CHAN_W-1:0]   blue,
   output logic                out_valid,
   output div_stage_type       out_data
);

   logic                va_ff;
   logic                vb_ff;
   logic [CHAN_W-1:0]   mx_ff;
   logic [CHAN_W-1:0]   delta_ff;
   logic signed [CHAN_W:0] diff_ff;
   sector_type          sect_ff;
   logic [CHAN_W-1:0]   mx_in;
   logic [CHAN_W-1:0]   delta_in;
   logic signed [CHAN_W:0] diff_in;
   sector_type          sect_in;
   div_stage_type       data_ff;
   div_stage_type       data_in;

   // Stage A: largest and smallest channel, sector and signed difference.
   always_comb begin
      logic [CHAN_W-1:0] m;
      logic [CHAN_W-1:0] n;
      m = (red > green) ? red : green;
      m = (m > blue) ? m : blue;
      n = (red < green) ? red : green;
      n = (n < blue) ? n : blue;
      mx_in    = m;
      delta_in = m - n;
      if (red == m) begin
         sect_in = SECT_RED;
         diff_in = $signed({1'b0, green}) - $signed({1'b0, blue});
      end else if (green == m) begin
         sect_in = SECT_GREEN;
         diff_in = $signed({1'b0, blue}) - $signed({1'b0, red});
      end else begin
         sect_in = SECT_BLUE;
         diff_in = $signed({1'b0, red}) - $signed({1'b0, green});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff    <= mx_in;
         delta_ff <= delta_in;
         diff_ff  <= diff_in;
         sect_ff  <= sect_in;
      end
   end

   // Stage B: dividends and divisors. A negative red-sector hue wraps by
   // using six sectors as offset, so the hue dividend is never negative.
   // A zero divisor becomes one; its dividend is zero in that case.
   always_comb begin
      logic [10:0]        off_delta;
      logic [10:0]        t;
      logic [DIVIDEND_W-1:0] t_w;
      logic [DIVIDEND_W-1:0] sat_num;
      logic [DIVIDEND_W-1:0] hue_num;
      case (sect_ff)
         SECT_RED:   off_delta = diff_ff[CHAN_W] ?
                                 ({1'b0, delta_ff, 2'b0} + {2'b0, delta_ff, 1'b0}) : 11'd0;
         SECT_GREEN: off_delta = {2'b0, delta_ff, 1'b0};
         SECT_BLUE:  off_delta = {1'b0, delta_ff, 2'b0};
         default:    off_delta = 11'd0;
      endcase
      t       = off_delta + {{2{diff_ff[CHAN_W]}}, diff_ff};
      t_w     = {13'b0, t};
      // 3840 = 4096 - 256
      hue_num = (t_w << 12) - (t_w << 8);
      sat_num = {delta_ff, 16'b0} - {16'b0, delta_ff};

      data_in.value    = mx_ff;
      data_in.sat.rem  = sat_num[DIVIDEND_W-1:QUO_W];
      data_in.sat.bits = sat_num[QUO_W-1:0];
      data_in.sat.dvs  = (mx_ff == '0) ? 8'd1 : mx_ff;
      data_in.hue.rem  = hue_num[DIVIDEND_W-1:QUO_W];
      data_in.hue.bits = hue_num[QUO_W-1:0];
      data_in.hue.dvs  = (delta_ff == '0) ? 8'd1 : delta_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (en) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = vb_ff;
   assign out_data  = data_ff;

endmodule

// ===== hw/rtl/rgbhsv_div.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV divider pipeline
// Restoring division for saturation and hue side by side, two quotient bits
// per register stage.
// ----------------------------------------------------------------------------
module rgbhsv_div
   import rgbhsv_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  div_stage_type  in_data,
   output logic           out_valid,
   output div_stage_type  out_data
);

   logic [DIV_STAGES-1:0] valid_ff;
   div_stage_type         st_ff [DIV_STAGES];
   div_stage_type         st_in [DIV_STAGES];

   // Each stage takes the previous stage and runs its division steps.
   always_comb begin
      div_stage_type cur;
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (k == 0) begin
            cur = in_data;
         end else begin
            cur = st_ff[k-1];
         end
         for (int j = 0; j < BITS_PER_STAGE; j++) begin
            cur.sat = div_step(cur.sat);
            cur.hue = div_step(cur.hue);
         end
         st_in[k] = cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_data  = st_ff[DIV_STAGES-1];

endmodule

// ===== hw/rtl/rgb_to_hsv_converter_unit.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV converter, top level
// Converts one 8-bit RGB pixel per clock, unless the receiver stalls, into hue, saturation and value.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the req_ stream: one item per pixel, red, green and blue
//   packed in req_tdata. Results leave on the rsp_ stream in the same order,
//   one item per pixel: hue (degrees times 64), saturation (times 65535) and
//   value (the largest channel).
//   Throughput is one item per clock while the receiver keeps up. From the
//   accepting edge to rsp_tvalid the item passes eleven registers, the first
//   loaded at the accepting edge: two front stages (max/min, then dividends),
//   eight divider stages at two quotient bits each for the 16-bit quotients,
//   and the output register.
//   Reset clears all valid bits; no item is in flight afterwards and
//   req_tready is high.
//   When the receiver stalls, a result waits in the output register while
//   the pipeline keeps moving and keeps accepting items until an item reaches
//   the last divider stage; then the whole pipeline holds until the output
//   register is taken. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_unit
   import rgbhsv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // red [7:0], green [15:8], blue [23:16]
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // hue [14:0], saturation [30:15], value [38:31]
);

   logic             en;
   logic             front_valid;
   div_stage_type    front_data;
   logic             div_valid;
   div_stage_type    div_data;
   logic             rsp_valid_ff;
   logic [RSP_W-1:0] rsp_data_ff;
   logic [RSP_W-1:0] rsp_data_in;
   logic             out_free;

   // The pipeline holds only when its last stage has an item the full,
   // stalled output register cannot take.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign en         = out_free || !div_valid;
   assign req_tready = en;

   rgbhsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .red       (req_tdata[7:0]),
      .green     (req_tdata[15:8]),
      .blue      (req_tdata[23:16]),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   rgbhsv_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   // Result packing.
   assign rsp_data_in = {1'b0, div_data.value, div_data.sat.bits,
                         div_data.hue.bits[HUE_W-1:0]};

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && div_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Hue stays below a full turn.
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[14:0] < HUE_FULL))
      else $error("hue out of range");

   // A black pixel has zero hue and saturation.
   a_black: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[38:31] == 8'd0) |->
      (rsp_tdata[30:15] == 16'd0 && rsp_tdata[14:0] == 15'd0))
      else $error("black pixel with nonzero hue or saturation");

   // A gray pixel (zero saturation) has zero hue.
   a_gray: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[30:15] == 16'd0) |-> (rsp_tdata[14:0] == 15'd0))
      else $error("gray pixel with nonzero hue");

   // Input back-pressure only while a result is stalled at the output.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without output stall");

endmodule

// ===== tb/sv/rgb_to_hsv_checker.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV converter checker
// Watches both streams of the converter, predicts hue, saturation and value
// for every accepted pixel, and compares each result item in order.
// ----------------------------------------------------------------------------
module rgb_to_hsv_checker
   import rgbhsv_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // red [7:0], green [15:8], blue [23:16]
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,   // hue [14:0], saturation [30:15], value [38:31]
   output int               fail_count,
   output int               pending_count
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAT_FULL = 65535;

   // Result item as it sits on rsp_tdata, highest bits first.
   typedef struct packed {
      logic              pad;
      logic [CHAN_W-1:0] value;
      logic [SAT_W-1:0]  saturation;
      logic [HUE_W-1:0]  hue;
   } hsv_type;

   hsv_type hsv_expected_q[$];
   int      result_index;

   initial begin
      fail_count    = 0;
      pending_count = 0;
      result_index  = 0;
   end

   // Exact integer conversion of one pixel.
   function automatic hsv_type predict_hsv(logic [CHAN_W-1:0] red, logic [CHAN_W-1:0] green,
                                           logic [CHAN_W-1:0] blue);
      int         mx;
      int         mn;
      int         delta;
      int         offset;
      int         diff;
      int         num;
      sector_type sector;
      hsv_type    res;
      mx = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      mn = red;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;
      delta = mx - mn;
      res = '0;
      res.value = mx[CHAN_W-1:0];
      if (mx != 0) begin
         res.saturation = SAT_W'((delta * SAT_FULL) / mx);
         if (delta != 0) begin
            // Ties go to red first, then green.
            if (red == mx) sector = SECT_RED;
            else if (green == mx) sector = SECT_GREEN;
            else sector = SECT_BLUE;
            case (sector)
               SECT_RED: begin
                  offset = 0;
                  diff   = int'(green) - int'(blue);
               end
               SECT_GREEN: begin
                  offset = 2;
                  diff   = int'(blue) - int'(red);
               end
               default: begin
                  offset = 4;
                  diff   = int'(red) - int'(green);
               end
            endcase
            // Numerator is 64 * degrees * delta; wrap negative angles once.
            num = int'(HUE_SCALE) * (offset * delta + diff);
            if (num < 0) num += int'(HUE_FULL) * delta;
            res.hue = HUE_W'(num / delta);
         end
      end
      return res;
   endfunction

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(string what, logic [RSP_W-1:0] got, logic [RSP_W-1:0] want);
      $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h", result_index, what, got,
               want);
      fail_count++;
   endtask

   // Compare outgoing items first, then record the prediction for an incoming one.
   always @(posedge clock) begin : monitor
      hsv_type got;
      hsv_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (hsv_expected_q.size() == 0) begin
               report_mismatch("with no pixel pending", got, '0);
            end else begin
               want = hsv_expected_q.pop_front();
               if (got.hue !== want.hue)
                  report_mismatch("hue", RSP_W'(got.hue), RSP_W'(want.hue));
               if (got.saturation !== want.saturation)
                  report_mismatch("saturation", RSP_W'(got.saturation),
                                  RSP_W'(want.saturation));
               if (got.value !== want.value)
                  report_mismatch("value", RSP_W'(got.value), RSP_W'(want.value));
               if (got.pad !== want.pad)
                  report_mismatch("padding bit", RSP_W'(got.pad), RSP_W'(want.pad));
            end
            result_index++;
         end
         if (req_tvalid && req_tready)
            hsv_expected_q.push_back(predict_hsv(req_tdata[CHAN_W-1:0],
                                                 req_tdata[2*CHAN_W-1:CHAN_W],
                                                 req_tdata[3*CHAN_W-1:2*CHAN_W]));
         pending_count <= hsv_expected_q.size();
      end
   end

endmodule

// ===== tb/sv/tb_rgb_to_hsv_converter_unit.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV converter testbench
// Drives directed and random pixels under varying back pressure and idle
// gaps; the checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_converter_unit
   import rgbhsv_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_PIXELS  = 300;
   localparam int TAIL_CYCLES   = 30;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;    // red [7:0], green [15:8], blue [23:16]
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;    // hue [14:0], saturation [30:15], value [38:31]

   int fail_count;
   int pending_count;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // Directed pixels, written as blue, green, red.
   logic [REQ_W-1:0] directed_pixels[$] = '{
      24'h000000, 24'hffffff, 24'h808080, 24'h010101, 24'h0000ff, 24'h00ff00,
      24'hff0000, 24'h00ffff, 24'hffff00, 24'hff00ff, 24'h000001, 24'h000100,
      24'h010000, 24'h0100ff, 24'h01ff00, 24'h00feff, 24'hfe00ff, 24'hc83264,
      24'h7f807f
   };

   rgb_to_hsv_converter_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   rgb_to_hsv_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver back pressure.
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Channel value biased toward the ends of the range.
   function automatic logic [CHAN_W-1:0] random_channel();
      case ($urandom_range(15))
         0:       return '0;
         1:       return '1;
         default: return CHAN_W'($urandom_range(255));
      endcase
   endfunction

   // Random pixel: mostly free content, with gray, black, tied maxima and corners mixed in.
   function automatic logic [REQ_W-1:0] random_pixel();
      logic [CHAN_W-1:0] hi;
      logic [CHAN_W-1:0] lo;
      hi = random_channel();
      lo = CHAN_W'($urandom_range(hi));
      case ($urandom_range(15))
         0: return {hi, hi, hi};
         1: return '0;
         2: begin
            case ($urandom_range(2))
               0:       return {lo, hi, hi};
               1:       return {hi, hi, lo};
               default: return {hi, lo, hi};
            endcase
         end
         3: return {{CHAN_W{$urandom_range(1) == 1}}, {CHAN_W{$urandom_range(1) == 1}},
                    {CHAN_W{$urandom_range(1) == 1}}};
         default: return {random_channel(), random_channel(), random_channel()};
      endcase
   endfunction

   // Offer one pixel after a random idle gap and hold it until it is accepted.
   task automatic send_pixel(logic [REQ_W-1:0] pixel);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pixel;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop sending until every predicted result has come out.
   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed corners: black, grays, primaries, tied maxima and hue wraparound.
      foreach (directed_pixels[i]) send_pixel(directed_pixels[i]);
      wait_for_drain();

      // Random phases: sender idles lightly with a slow receiver, then the reverse,
      // then both run flat out.
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 80 : 0;
         recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 14 : 0;
         for (int n = 0; n < PHASE_PIXELS; n++) begin
            if (n == PHASE_PIXELS / 2) wait_for_drain();
            send_pixel(random_pixel());
         end
         wait_for_drain();
      end

      // Let the pipeline settle so any stray result shows up.
      while (pending_count != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
